// File: src/dual_port_ram_command_mailbox_defines.svh
// Assertion macros shared by the mailbox queue and executor RTL files.
`ifndef DUAL_PORT_RAM_COMMAND_MAILBOX_DEFINES_SVH
`define DUAL_PORT_RAM_COMMAND_MAILBOX_DEFINES_SVH
`ifndef SYNTHESIS
`define DPRCM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DPRCM_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) !rst_n |=> prop) else $error(msg);
`else
`define DPRCM_ASSERT(lbl, clk, rst_n, prop, msg)
`define DPRCM_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`endif
`endif

// File: src/dprcm_pkg.sv
// Types, constants and helper functions of the shared RAM command mailbox.
`default_nettype none
package dprcm_pkg;

    localparam int RAM_BYTES    = 16384;
    localparam int RAM_AW       = $clog2(RAM_BYTES);
    localparam int MAX_CPUS     = 4;
    localparam int CPU_ID_W     = $clog2(MAX_CPUS);
    localparam int CPU_COUNT_W  = 3;
    localparam int OFFSET_W     = 20;
    localparam int OFFSET_SHIFT = 6;
    localparam int BYTE_W       = 8;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 16;
    // Queue depth must be a power of two so that the pointers wrap by themselves.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    typedef logic [RAM_AW-1:0]      t_idx;
    typedef logic [BYTE_W-1:0]      t_byte;
    typedef logic [CPU_ID_W-1:0]    t_cpu_id;
    typedef logic [CPU_COUNT_W-1:0] t_cpus;

    localparam t_cpus CPU_COUNT_RESET = 3'd4;

    // Mailbox byte locations.
    localparam t_idx IDX_COUNT  = 14'h00f9;
    localparam t_idx IDX_OFFSET = 14'h00fa;
    localparam t_idx IDX_QUAL   = 14'h00fb;
    localparam t_idx IDX_DONE   = 14'h00fc;
    localparam t_idx IDX_RESP   = 14'h00fd;
    localparam t_idx IDX_CMD    = 14'h00fe;
    localparam t_idx IDX_GO     = 14'h00ff;
    localparam t_idx STAGE_BASE = 14'h3500;
    localparam t_idx JUMP_FLAG_BASE = 14'h3418;
    localparam t_idx JUMP_STRIDE    = 14'h0010;

    // Command codes and completion codes.
    localparam t_byte CMD_COPY      = 8'h01;
    localparam t_byte CMD_NOP_A     = 8'h02;
    localparam t_byte CMD_NOP_B     = 8'h03;
    localparam t_byte CMD_NOP_C     = 8'hf0;
    localparam t_byte DONE_OK       = 8'h00;
    localparam t_byte DONE_BAD_QUAL = 8'h80;
    localparam t_byte DONE_BAD_CMD  = 8'h81;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_WR_GO   = 2'd2,
        OP_WR_RESP = 2'd3
    } t_op;

    typedef struct packed {
        t_op     op;
        t_idx    idx;
        t_byte   data;
        t_cpu_id start;
    } t_cmd;

    // Processor qualifiers need a present processor, the others are fixed ranges.
    function automatic logic qual_ok(t_byte q, t_cpus cpus);
        logic ok;
        ok = 1'b0;
        if (q >= 8'h21 && q <= 8'h24) begin
            ok = (q - 8'h20) <= {5'd0, cpus};
        end else if ((q >= 8'h01 && q <= 8'h2a) || (q >= 8'h31 && q <= 8'h33) ||
                     (q >= 8'h3b && q <= 8'h3f)) begin
            ok = 1'b1;
        end
        return ok;
    endfunction

endpackage
`default_nettype wire

// File: src/dprcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dprcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: src/dprcm_front.sv
// Front end: takes bus beats, maps the offset to a RAM index and classifies the access.
`default_nettype none
module dprcm_front (
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [dprcm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic [0:0]                          s_axis_tuser,
    input  wire dprcm_pkg::t_cpus                    i_cpu_count,
    input  wire logic                                i_clearing,
    input  wire logic                                i_full,
    output logic                                     o_push,
    output dprcm_pkg::t_cmd                          o_cmd
);

    logic                                   mode;
    logic [dprcm_pkg::OFFSET_W-1:0]         offset;
    dprcm_pkg::t_idx                        idx;
    dprcm_pkg::t_byte                       wdata;
    logic [dprcm_pkg::MAX_CPUS-1:0]         waiting;
    dprcm_pkg::t_cpu_id                     start_req;

    assign mode    = s_axis_tuser[0];
    assign offset  = s_axis_tdata[dprcm_pkg::OFFSET_W-1:0];
    assign wdata   = s_axis_tdata[dprcm_pkg::OFFSET_W +: dprcm_pkg::BYTE_W];
    assign waiting = s_axis_tdata[dprcm_pkg::OFFSET_W + dprcm_pkg::BYTE_W +: dprcm_pkg::MAX_CPUS];
    assign idx     = offset[dprcm_pkg::OFFSET_W-1:dprcm_pkg::OFFSET_SHIFT];

    // Each secondary processor has a jump flag; a write to it may start that processor.
    always_comb begin
        start_req = '0;
        for (int n = 1; n < dprcm_pkg::MAX_CPUS; n++) begin
            if (mode && idx == dprcm_pkg::JUMP_FLAG_BASE +
                    dprcm_pkg::t_idx'(n) * dprcm_pkg::JUMP_STRIDE &&
                    dprcm_pkg::t_cpus'(n) < i_cpu_count && waiting[n]) begin
                start_req = dprcm_pkg::t_cpu_id'(n);
            end
        end
    end

    always_comb begin
        o_cmd.idx   = idx;
        o_cmd.data  = wdata;
        o_cmd.start = start_req;
        priority if (!mode) begin
            o_cmd.op = dprcm_pkg::OP_READ;
        end else if (idx == dprcm_pkg::IDX_GO) begin
            o_cmd.op = dprcm_pkg::OP_WR_GO;
        end else if (idx == dprcm_pkg::IDX_RESP) begin
            o_cmd.op = dprcm_pkg::OP_WR_RESP;
        end else begin
            o_cmd.op = dprcm_pkg::OP_WRITE;
        end
    end

    assign s_axis_tready = !i_full && !i_clearing;
    assign o_push        = s_axis_tvalid && s_axis_tready;

endmodule
`default_nettype wire

// File: src/dprcm_fifo.sv
// Short queue of decoded accesses between the front end and the executor.
`default_nettype none
`include "dual_port_ram_command_mailbox_defines.svh"
module dprcm_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire dprcm_pkg::t_cmd i_cmd,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output dprcm_pkg::t_cmd      o_cmd
);

    dprcm_pkg::t_cmd                    r_entries [dprcm_pkg::QUEUE_DEPTH];
    logic [dprcm_pkg::QUEUE_AW-1:0]     r_wr_ptr;
    logic [dprcm_pkg::QUEUE_AW-1:0]     r_rd_ptr;
    logic [dprcm_pkg::QUEUE_CNT_W-1:0]  r_count;
    logic [dprcm_pkg::QUEUE_CNT_W-1:0]  n_count;
    logic                               do_push;
    logic                               do_pop;

    assign o_full  = r_count == dprcm_pkg::QUEUE_CNT_W'(dprcm_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_entries[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

    `DPRCM_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= dprcm_pkg::QUEUE_CNT_W'(dprcm_pkg::QUEUE_DEPTH), "queue count beyond depth")
    `DPRCM_ASSERT(a_pop_nonempty, i_clk, i_rst_n, i_pop |-> (r_count != '0), "pop from an empty queue")

endmodule
`default_nettype wire

// File: src/dprcm_back.sv
// Executor: clears the RAM after reset, then carries out reads, writes and mailbox commands.
`default_nettype none
`include "dual_port_ram_command_mailbox_defines.svh"
module dprcm_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dprcm_pkg::t_cpus    i_cpu_count,
    input  wire logic                i_valid,
    input  wire dprcm_pkg::t_cmd     i_cmd,
    output logic                     o_pop,
    output logic                     o_clearing,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output dprcm_pkg::t_byte         o_out_data,
    output dprcm_pkg::t_cpu_id       o_out_start
);

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_RD      = 11'b000_0000_0100,
        S_ECHO    = 11'b000_0000_1000,
        S_CMD     = 11'b000_0001_0000,
        S_QUAL    = 11'b000_0010_0000,
        S_OFF     = 11'b000_0100_0000,
        S_CNT     = 11'b000_1000_0000,
        S_COPY_RD = 11'b001_0000_0000,
        S_COPY_WR = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } t_state;

    t_state             r_state,     n_state;
    dprcm_pkg::t_idx    r_clr_addr,  n_clr_addr;
    dprcm_pkg::t_byte   r_data,      n_data;
    dprcm_pkg::t_byte   r_q,         n_q;
    dprcm_pkg::t_byte   r_off,       n_off;
    dprcm_pkg::t_byte   r_cnt,       n_cnt;
    dprcm_pkg::t_byte   r_i,         n_i;
    dprcm_pkg::t_byte   r_code,      n_code;
    logic               r_out_valid, n_out_valid;
    dprcm_pkg::t_byte   r_out_data,  n_out_data;
    dprcm_pkg::t_cpu_id r_out_start, n_out_start;

    logic               ram_we;
    dprcm_pkg::t_idx    ram_waddr;
    dprcm_pkg::t_byte   ram_wdata;
    dprcm_pkg::t_idx    ram_raddr;
    dprcm_pkg::t_byte   ram_rdata;
    dprcm_pkg::t_idx    copy_src;
    dprcm_pkg::t_idx    copy_dst;
    logic               slot_free;

    dprcm_ram #(
        .WIDTH (dprcm_pkg::BYTE_W),
        .DEPTH (dprcm_pkg::RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Destination wraps at the RAM size, so only the low qualifier bits matter.
    assign copy_src = dprcm_pkg::STAGE_BASE + {6'd0, r_off} + {6'd0, r_i};
    assign copy_dst = {r_q[5:0], 8'h00} + {6'd0, r_off} + {6'd0, r_i};
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_data      = r_data;
        n_q         = r_q;
        n_off       = r_off;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_code      = r_code;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        n_out_start = r_out_start;
        ram_we      = 1'b0;
        ram_waddr   = i_cmd.idx;
        ram_wdata   = i_cmd.data;
        ram_raddr   = i_cmd.idx;
        o_pop       = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid && slot_free) begin
                    o_pop  = 1'b1;
                    n_data = i_cmd.data;
                    unique case (i_cmd.op)
                        dprcm_pkg::OP_READ: begin
                            n_state = S_RD;
                        end
                        dprcm_pkg::OP_WRITE: begin
                            ram_we      = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_data  = '0;
                            n_out_start = i_cmd.start;
                        end
                        dprcm_pkg::OP_WR_RESP: begin
                            ram_we  = 1'b1;
                            n_state = S_ECHO;
                        end
                        dprcm_pkg::OP_WR_GO: begin
                            ram_we    = 1'b1;
                            ram_raddr = dprcm_pkg::IDX_CMD;
                            n_state   = S_CMD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_out_valid = 1'b1;
                n_out_data  = ram_rdata;
                n_out_start = '0;
                n_state     = S_IDLE;
            end
            S_ECHO: begin
                ram_we      = 1'b1;
                ram_waddr   = dprcm_pkg::IDX_GO;
                ram_wdata   = r_data;
                n_out_valid = 1'b1;
                n_out_data  = '0;
                n_out_start = '0;
                n_state     = S_IDLE;
            end
            S_CMD: begin
                // The go byte is echoed into the response byte; the command code is in.
                ram_we    = 1'b1;
                ram_waddr = dprcm_pkg::IDX_RESP;
                ram_wdata = r_data;
                ram_raddr = dprcm_pkg::IDX_QUAL;
                if (ram_rdata == dprcm_pkg::CMD_COPY) begin
                    n_state = S_QUAL;
                end else if (ram_rdata == dprcm_pkg::CMD_NOP_A ||
                             ram_rdata == dprcm_pkg::CMD_NOP_B ||
                             ram_rdata == dprcm_pkg::CMD_NOP_C) begin
                    n_code  = dprcm_pkg::DONE_OK;
                    n_state = S_DONE;
                end else begin
                    n_code  = dprcm_pkg::DONE_BAD_CMD;
                    n_state = S_DONE;
                end
            end
            S_QUAL: begin
                n_q       = ram_rdata;
                ram_raddr = dprcm_pkg::IDX_OFFSET;
                n_state   = S_OFF;
            end
            S_OFF: begin
                n_off     = ram_rdata;
                ram_raddr = dprcm_pkg::IDX_COUNT;
                n_state   = S_CNT;
            end
            S_CNT: begin
                n_cnt = ram_rdata;
                n_i   = '0;
                if (dprcm_pkg::qual_ok(r_q, i_cpu_count)) begin
                    n_state = S_COPY_RD;
                end else begin
                    n_code  = dprcm_pkg::DONE_BAD_QUAL;
                    n_state = S_DONE;
                end
            end
            S_COPY_RD: begin
                ram_raddr = copy_src;
                n_state   = S_COPY_WR;
            end
            S_COPY_WR: begin
                ram_we    = 1'b1;
                ram_waddr = copy_dst;
                ram_wdata = ram_rdata;
                if (r_i == r_cnt) begin
                    n_code  = dprcm_pkg::DONE_OK;
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_COPY_RD;
                end
            end
            S_DONE: begin
                ram_we      = 1'b1;
                ram_waddr   = dprcm_pkg::IDX_DONE;
                ram_wdata   = r_code;
                n_out_valid = 1'b1;
                n_out_data  = '0;
                n_out_start = '0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data      <= n_data;
        r_q         <= n_q;
        r_off       <= n_off;
        r_cnt       <= n_cnt;
        r_i         <= n_i;
        r_code      <= n_code;
        r_out_data  <= n_out_data;
        r_out_start <= n_out_start;
    end

    assign o_clearing  = r_state == S_CLEAR;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_start = r_out_start;

    `DPRCM_ASSERT_RST(a_reset_clears, i_clk, i_rst_n, (o_clearing && !r_out_valid), "reset did not start the clearing sweep")
    `DPRCM_ASSERT(a_pop_slot, i_clk, i_rst_n, o_pop |-> (!r_out_valid || i_out_ready), "access taken while the output slot is held")
    `DPRCM_ASSERT(a_copy_bound, i_clk, i_rst_n, (r_state == S_COPY_RD || r_state == S_COPY_WR) |-> (r_i <= r_cnt), "copy index ran past the count")
    `DPRCM_ASSERT(a_sweep_done, i_clk, i_rst_n, $fell(o_clearing) |-> $past(&r_clr_addr), "clearing ended before the last entry")

endmodule
`default_nettype wire

// File: src/dual_port_ram_command_mailbox.sv
// Top level: a plain write gives its result as the executor takes it, a read once its RAM
// data returns. Sustained rate: one write per cycle while the result side is ready; a read
// holds the executor until its data is out. A copy loads its operands, then does one read
// and one write of the shared RAM per byte. Reset (synchronous) sets cpu_count to 4 and
// zeroes all 16384 RAM bytes, one byte a cycle; no beat is taken meanwhile.
`default_nettype none
module dual_port_ram_command_mailbox (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // bus_offset[19:0], write_data[27:20], cpu_waiting[31:28]
    input  wire logic [dprcm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // mode[0]
    input  wire logic [0:0]                          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // read_data[7:0], start_cpu[9:8], zero above
    output logic      [dprcm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire dprcm_pkg::t_cpus                    i_cfg_data
);

    dprcm_pkg::t_cpus   r_cpu_count;
    logic               clearing;
    logic               fifo_full;
    logic               push;
    dprcm_pkg::t_cmd    push_cmd;
    logic               pop;
    logic               queue_valid;
    dprcm_pkg::t_cmd    queue_cmd;
    dprcm_pkg::t_byte   out_data;
    dprcm_pkg::t_cpu_id out_start;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_count <= dprcm_pkg::CPU_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cpu_count <= i_cfg_data;
        end
    end

    dprcm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cpu_count   (r_cpu_count),
        .i_clearing    (clearing),
        .i_full        (fifo_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    dprcm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    dprcm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cpu_count (r_cpu_count),
        .i_valid     (queue_valid),
        .i_cmd       (queue_cmd),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (out_data),
        .o_out_start (out_start)
    );

    assign m_axis_tdata = {6'd0, out_start, out_data};

endmodule
`default_nettype wire

// File: tb/sv/dual_port_ram_command_mailbox_checker.sv
// Checker for the shared RAM command mailbox: predicts each access and compares its result beat.
`timescale 1ns / 1ps
module dual_port_ram_command_mailbox_checker
    import dprcm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    // bus_offset[19:0], write_data[27:20], cpu_waiting[31:28]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic [0:0]             s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // read_data[7:0], start_cpu[9:8], zero above
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  t_cpus                  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        t_byte       read_data;
        logic [1:0]  start_cpu;
    } t_access_result;

    t_byte          ram_image [RAM_BYTES];
    t_cpus          cpus_cfg;
    t_access_result owed_results [$];
    int             mismatches = 0;

    function automatic int unsigned cpus_present();
        return (cpus_cfg > MAX_CPUS) ? MAX_CPUS : cpus_cfg;
    endfunction

    // Processor qualifiers are valid only for processors that are present.
    function automatic logic qualifier_valid(t_byte q);
        if (q >= 8'h21 && q <= 8'h24) begin
            return (q - 8'h20) <= cpus_present();
        end
        return (q >= 8'h01 && q <= 8'h2a) || (q >= 8'h31 && q <= 8'h33) ||
               (q >= 8'h3b && q <= 8'h3f);
    endfunction

    function automatic void run_mailbox_command();
        t_byte       cmd_code;
        t_byte       qual;
        t_byte       src_off;
        t_byte       done_code;
        int unsigned nbytes;
        int unsigned i;
        t_idx        src;
        t_idx        dst;
        cmd_code = ram_image[IDX_CMD];
        ram_image[IDX_RESP] = ram_image[IDX_GO];
        if (cmd_code == CMD_COPY) begin
            // Operands are taken once, so a copy landing on them does not change this one.
            qual = ram_image[IDX_QUAL];
            src_off = ram_image[IDX_OFFSET];
            nbytes = ram_image[IDX_COUNT] + 1;
            if (qualifier_valid(qual)) begin
                for (i = 0; i < nbytes; i++) begin
                    src = t_idx'(STAGE_BASE + src_off + i);
                    dst = t_idx'(qual * 32'h100 + src_off + i);
                    ram_image[dst] = ram_image[src];
                end
                done_code = DONE_OK;
            end else begin
                done_code = DONE_BAD_QUAL;
            end
        end else if (cmd_code == CMD_NOP_A || cmd_code == CMD_NOP_B || cmd_code == CMD_NOP_C) begin
            done_code = DONE_OK;
        end else begin
            done_code = DONE_BAD_CMD;
        end
        ram_image[IDX_DONE] = done_code;
    endfunction

    function automatic t_access_result predict_access(logic is_write, t_idx idx, t_byte wdata,
                                                      logic [3:0] waiting);
        t_access_result res;
        t_idx           rel;
        int unsigned    cpu;
        res = '0;
        if (!is_write) begin
            res.read_data = ram_image[idx];
        end else begin
            ram_image[idx] = wdata;
            if (idx == IDX_GO) begin
                run_mailbox_command();
            end else if (idx == IDX_RESP) begin
                ram_image[IDX_GO] = ram_image[IDX_RESP];
            end else if (idx > JUMP_FLAG_BASE && idx < JUMP_FLAG_BASE + 4 * JUMP_STRIDE) begin
                rel = idx - JUMP_FLAG_BASE;
                if (rel[3:0] == 4'd0) begin
                    cpu = rel >> 4;
                    if (cpu < cpus_present() && waiting[cpu]) begin
                        res.start_cpu = cpu[1:0];
                    end
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_access_result want;
        if (!i_rst_n) begin
            foreach (ram_image[k]) ram_image[k] = '0;
            cpus_cfg = CPU_COUNT_RESET;
            owed_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                cpus_cfg = i_cfg_data;
            end
            // A result beat accepted with an access beat belongs to an earlier access.
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_results.size() == 0) begin
                    $error("result beat with no access outstanding: tdata %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_axis_tdata[7:0] !== want.read_data) begin
                        $error("read_data: expected %h, actual %h", want.read_data,
                               m_axis_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[9:8] !== want.start_cpu) begin
                        $error("start_cpu: expected %0d, actual %0d", want.start_cpu,
                               m_axis_tdata[9:8]);
                        mismatches++;
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1:10] !== '0) begin
                        $error("pad: expected 0, actual %h", m_axis_tdata[OUT_TDATA_W-1:10]);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                owed_results.push_back(predict_access(s_axis_tuser[0],
                                                      t_idx'(s_axis_tdata[19:6]),
                                                      s_axis_tdata[27:20],
                                                      s_axis_tdata[31:28]));
            end
        end
        o_pending <= owed_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: tb/sv/dual_port_ram_command_mailbox_tb.sv
// Testbench top for the shared RAM command mailbox: drives bus accesses and gives the verdict.
`timescale 1ns / 1ps
module dual_port_ram_command_mailbox_tb;
    import dprcm_pkg::*;

    localparam logic  MODE_READ          = 1'b0;
    localparam logic  MODE_WRITE         = 1'b1;
    localparam t_byte CMD_UNKNOWN        = 8'h55;
    localparam int    PHASE_COUNT        = 7;
    localparam int    RANDOM_PHASE_ITEMS = 130;
    localparam int    SETTLE_CYCLES      = 600;
    localparam int    TAIL_CYCLES        = 20;
    localparam int    LONG_HOLD_CYCLES   = 300;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    t_cpus                  i_cfg_data = '0;

    int fail_count;
    int results_owed;
    int accesses_sent = 0;
    int rx_hold_cycles = 0;
    bit link_quiet = 1'b0;

    always #6 i_clk = ~i_clk;

    dual_port_ram_command_mailbox dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    dual_port_ram_command_mailbox_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (results_owed)
    );

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OFFSET_W-1:0] offset_of(t_idx idx);
        return {idx, 6'($urandom)};
    endfunction

    function automatic t_byte pick_qualifier();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(8'h01, 8'h2a));
            4:          return 8'($urandom_range(8'h21, 8'h24));
            5:          return 8'($urandom_range(8'h31, 8'h33));
            6:          return 8'($urandom_range(8'h3b, 8'h3f));
            7: begin
                case ($urandom_range(0, 3))
                    0:       return 8'h00;
                    1:       return 8'($urandom_range(8'h2b, 8'h30));
                    2:       return 8'($urandom_range(8'h34, 8'h3a));
                    default: return 8'($urandom_range(8'h40, 8'hff));
                endcase
            end
            default:    return 8'($urandom);
        endcase
    endfunction

    // Offers one access beat after a random gap and waits until it is taken.
    task automatic issue_access(logic mode, logic [OFFSET_W-1:0] offset, t_byte data,
                                logic [3:0] waiting);
        int gap;
        gap = (link_quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {waiting, data, offset};
        s_axis_tuser <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        accesses_sent++;
    endtask

    task automatic write_byte(t_idx idx, t_byte data);
        issue_access(MODE_WRITE, offset_of(idx), data, 4'($urandom));
    endtask

    task automatic read_byte(t_idx idx);
        issue_access(MODE_READ, offset_of(idx), 8'($urandom), 4'($urandom));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
    endtask

    task automatic write_cpu_count(t_cpus value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A mailbox command as software issues it; an operand write is sometimes left out.
    task automatic mailbox_command();
        t_byte qual;
        t_byte src_off;
        t_byte cnt;
        t_byte cmd_code;
        int    r;
        qual = pick_qualifier();
        src_off = 8'($urandom);
        cnt = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 65)      cmd_code = CMD_COPY;
        else if (r < 72) cmd_code = CMD_NOP_A;
        else if (r < 79) cmd_code = CMD_NOP_B;
        else if (r < 86) cmd_code = CMD_NOP_C;
        else             cmd_code = 8'($urandom);
        repeat ($urandom_range(0, 3)) begin
            write_byte(t_idx'(STAGE_BASE + src_off + $urandom_range(0, cnt)), 8'($urandom));
        end
        if ($urandom_range(0, 9) != 0) write_byte(IDX_QUAL, qual);
        if ($urandom_range(0, 9) != 0) write_byte(IDX_OFFSET, src_off);
        if ($urandom_range(0, 9) != 0) write_byte(IDX_COUNT, cnt);
        if ($urandom_range(0, 9) != 0) write_byte(IDX_CMD, cmd_code);
        write_byte(IDX_GO, 8'($urandom));
        read_byte(($urandom_range(0, 9) < 7) ? IDX_DONE : IDX_RESP);
        if (cmd_code == CMD_COPY) begin
            read_byte(t_idx'(qual * 32'h100 + src_off + $urandom_range(0, cnt)));
        end
    endtask

    task automatic random_activity();
        int r;
        int cpu;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            mailbox_command();
        end else if (r < 55) begin
            write_byte(t_idx'(STAGE_BASE + $urandom_range(0, 511)), 8'($urandom));
        end else if (r < 65) begin
            // Jump flags, now and then slightly off the flag location.
            cpu = $urandom_range(0, 4);
            issue_access(MODE_WRITE,
                         offset_of(t_idx'(JUMP_FLAG_BASE + cpu * JUMP_STRIDE +
                                   (($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0))),
                         8'($urandom), 4'($urandom));
        end else if (r < 70) begin
            write_byte(IDX_RESP, 8'($urandom));
            read_byte(IDX_GO);
        end else if (r < 85) begin
            read_byte(($urandom_range(0, 1) == 0) ? t_idx'($urandom_range(8'hf8, 8'hff))
                                                  : t_idx'($urandom));
        end else begin
            write_byte(t_idx'($urandom), 8'($urandom));
        end
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                stall_left = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (link_quiet || $urandom_range(0, 99) < 70) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                stall_left = idle_len() - 1;
            end
        end
    end

    initial begin
        t_cpus phase_cpus [PHASE_COUNT];
        int    phase_end;
        phase_cpus = '{3'd7, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Offset extremes.
        issue_access(MODE_READ, 20'hfffff, 8'hff, 4'hf);
        issue_access(MODE_WRITE, 20'hfffff, 8'hff, 4'hf);
        issue_access(MODE_READ, 20'h00000, 8'h00, 4'h0);
        read_byte(t_idx'('1));
        // Full-length copy whose destination wraps around onto the mailbox operands.
        write_byte(IDX_QUAL, 8'h3f);
        write_byte(IDX_OFFSET, 8'hff);
        write_byte(IDX_COUNT, 8'hff);
        write_byte(IDX_CMD, CMD_COPY);
        write_byte(t_idx'(STAGE_BASE + 16'h01fa), 8'h5a);
        write_byte(IDX_GO, 8'h77);
        read_byte(IDX_DONE);
        read_byte(IDX_RESP);
        read_byte(IDX_OFFSET);
        // Bad qualifier, an accepted no-op and an unknown command.
        write_byte(IDX_QUAL, 8'h00);
        write_byte(IDX_CMD, CMD_COPY);
        write_byte(IDX_GO, 8'h01);
        read_byte(IDX_DONE);
        write_byte(IDX_CMD, CMD_NOP_C);
        write_byte(IDX_GO, 8'h02);
        write_byte(IDX_CMD, CMD_UNKNOWN);
        write_byte(IDX_GO, 8'h03);
        read_byte(IDX_DONE);
        // Response echo, then jump flags with and without a parked processor.
        write_byte(IDX_RESP, 8'h12);
        read_byte(IDX_GO);
        issue_access(MODE_WRITE, offset_of(t_idx'(JUMP_FLAG_BASE + JUMP_STRIDE)), 8'h01, 4'hf);
        issue_access(MODE_WRITE, offset_of(t_idx'(JUMP_FLAG_BASE + 3 * JUMP_STRIDE)), 8'h01,
                     4'h0);
        issue_access(MODE_WRITE, offset_of(JUMP_FLAG_BASE), 8'h01, 4'hf);
        drain_results();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            // Give the block some idle cycles before the processor count changes.
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            write_cpu_count(phase_cpus[p]);
            link_quiet = (p == 2);
            if (p == 4) rx_hold_cycles = LONG_HOLD_CYCLES;
            phase_end = accesses_sent + RANDOM_PHASE_ITEMS;
            while (accesses_sent < phase_end) random_activity();
            link_quiet = 1'b0;
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && results_owed == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: dual_port_ram_command_mailbox.f
+incdir+src
src/dprcm_pkg.sv
src/dprcm_ram.sv
src/dprcm_front.sv
src/dprcm_fifo.sv
src/dprcm_back.sv
src/dual_port_ram_command_mailbox.sv
tb/sv/dual_port_ram_command_mailbox_checker.sv
tb/sv/dual_port_ram_command_mailbox_tb.sv
